>>> hdl/ghd_pkg.sv
// ghd_pkg: types, widths, command and register codes for the grid heat diffusion block
// no dependencies; imported by every module of the block

package ghd_pkg;

	// field widths
	localparam int TEMP_W     = 17;
	localparam int COEF_W     = 15;
	localparam int PASS_W     = 4;
	localparam int DIM_W      = 7;
	localparam int CMD_W      = 2;
	localparam int COORD_W    = 6;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	// datapath widths of the update unit
	localparam int LAP_W      = 20;
	localparam int SUM_W      = LAP_W + 1;
	localparam int PROD_W     = LAP_W + COEF_W + 1;
	localparam int FRAC_SHIFT = 16;

	// commands
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RUN   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COEFF_OCEAN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEFF_LAND    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PASS_COUNT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_IN_USE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_IN_USE = 3'd4;

	// register reset values
	localparam logic [COEF_W-1:0] COEFF_OCEAN_RST = 15'd14418;
	localparam logic [COEF_W-1:0] COEFF_LAND_RST  = 15'd9175;
	localparam logic [PASS_W-1:0] PASS_COUNT_RST  = 4'd8;
	localparam logic [DIM_W-1:0]  WIDTH_RST       = 7'd64;
	localparam logic [DIM_W-1:0]  HEIGHT_RST      = 7'd64;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [COORD_W-1:0] cell_x;
		logic [COORD_W-1:0] cell_y;
		logic [TEMP_W-1:0]  temperature_in;
		logic               ocean_in;
	} request_t;

	typedef struct packed {
		logic [TEMP_W-1:0] temperature_out;
		logic              ocean_out;
		logic              run_done;
	} result_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COPY,
		ST_DRAIN,
		ST_CELL,
		ST_FINISH
	} state_t;

	// steps of one cell update: five snapshot reads, accumulate, multiply, write back
	typedef enum logic [2:0] {
		STEP_C,
		STEP_L,
		STEP_R,
		STEP_U,
		STEP_D,
		STEP_ACC,
		STEP_MUL,
		STEP_WB
	} cell_step_t;

	// memory controls from the sequencer
	typedef struct packed {
		logic grid_we;
		logic grid_from_alu;
		logic ocean_we;
		logic snap_we;
	} store_ctl_t;

	// update unit controls
	typedef struct packed {
		logic load;
		logic add;
		logic mul;
	} alu_ctl_t;

	// kind of the result shown in the next cycle
	typedef struct packed {
		logic vld;
		logic run;
		logic in_grid;
	} res_flags_t;

endpackage

>>> hdl/ghd_store.sv
// ghd_store: cell temperature, ocean flag and pass snapshot memories
// depends on ghd_pkg; all reads registered, one write port per memory

module ghd_store
	import ghd_pkg::*;
#(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                                       clk,
	input  store_ctl_t                                 ctl,
	input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]    grid_addr,
	input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]    snap_rd_addr,
	input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]    snap_wr_addr,
	input  logic [TEMP_W-1:0]                          wr_temp,
	input  logic                                       wr_ocean,
	input  logic [TEMP_W-1:0]                          alu_temp,
	output logic [TEMP_W-1:0]                          temp_rd,
	output logic                                       ocean_rd,
	output logic [TEMP_W-1:0]                          snap_rd
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

	logic [TEMP_W-1:0] temp_mem  [DEPTH];
	logic              ocean_mem [DEPTH];
	logic [TEMP_W-1:0] snap_mem  [DEPTH];

	logic [TEMP_W-1:0] temp_rd_q;
	logic              ocean_rd_q;
	logic [TEMP_W-1:0] snap_rd_q;

	// temperature store: command writes or updated cells
	always_ff @(posedge clk) begin
		if (ctl.grid_we) begin
			temp_mem[grid_addr] <= ctl.grid_from_alu ? alu_temp : wr_temp;
		end
		temp_rd_q <= temp_mem[grid_addr];
	end

	// ocean flags
	always_ff @(posedge clk) begin
		if (ctl.ocean_we) begin
			ocean_mem[grid_addr] <= wr_ocean;
		end
		ocean_rd_q <= ocean_mem[grid_addr];
	end

	// snapshot, filled from the registered temperature read
	always_ff @(posedge clk) begin
		if (ctl.snap_we) begin
			snap_mem[snap_wr_addr] <= temp_rd_q;
		end
		snap_rd_q <= snap_mem[snap_rd_addr];
	end

	assign temp_rd  = temp_rd_q;
	assign ocean_rd = ocean_rd_q;
	assign snap_rd  = snap_rd_q;

endmodule

>>> hdl/ghd_alu.sv
// ghd_alu: shared update unit, accumulates the laplacian, scales and saturates
// depends on ghd_pkg; driven step by step by ghd_ctrl

module ghd_alu
	import ghd_pkg::*;
(
	input  logic              clk,
	input  alu_ctl_t          ctl,
	input  logic [TEMP_W-1:0] snap_rd,
	input  logic              ocean,
	input  logic [COEF_W-1:0] coeff_ocean,
	input  logic [COEF_W-1:0] coeff_land,
	output logic [TEMP_W-1:0] new_temp
);

	logic [TEMP_W-1:0]        c_q;
	logic signed [LAP_W-1:0]  acc_q;
	logic signed [PROD_W-1:0] prod_q;

	logic signed [LAP_W-1:0]  data_ext;
	logic signed [COEF_W:0]   coef_s;
	logic signed [LAP_W-1:0]  delta;
	logic signed [SUM_W-1:0]  v;

	assign data_ext = $signed(LAP_W'(snap_rd));
	assign coef_s   = $signed({1'b0, (ocean ? coeff_ocean : coeff_land)});

	// centre loads -4c, neighbours add, then one multiply
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			c_q   <= snap_rd;
			acc_q <= '0 - (data_ext <<< 2);
		end else if (ctl.add) begin
			acc_q <= acc_q + data_ext;
		end
		if (ctl.mul) begin
			prod_q <= acc_q * coef_s;
		end
	end

	// floor shift, add to centre, saturate to the temperature range
	always_comb begin
		delta = LAP_W'(prod_q >>> FRAC_SHIFT);
		v     = $signed(SUM_W'(c_q)) + SUM_W'(delta);
		if (v[SUM_W-1]) begin
			new_temp = '0;
		end else if (v[SUM_W-2:TEMP_W] != '0) begin
			new_temp = '1;
		end else begin
			new_temp = v[TEMP_W-1:0];
		end
	end

endmodule

>>> hdl/ghd_ctrl.sv
// ghd_ctrl: command decode and run sequencer, walks cells and update steps
// depends on ghd_pkg; drives ghd_store and ghd_alu

module ghd_ctrl
	import ghd_pkg::*;
#(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      start,
	input  request_t                                  request,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]            width_eff,
	input  logic [$clog2(MAX_HEIGHT+1)-1:0]           height_eff,
	input  logic [PASS_W-1:0]                         pass_count,
	output logic                                      busy,
	output store_ctl_t                                store_ctl,
	output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]   grid_addr,
	output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]   snap_rd_addr,
	output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]   snap_wr_addr,
	output alu_ctl_t                                  alu_ctl,
	output res_flags_t                                res_flags
);

	localparam int XW  = $clog2(MAX_WIDTH);
	localparam int YW  = $clog2(MAX_HEIGHT);
	localparam int XW1 = $clog2(MAX_WIDTH + 1);
	localparam int YW1 = $clog2(MAX_HEIGHT + 1);
	localparam int AW  = $clog2(MAX_WIDTH * MAX_HEIGHT);

	function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] xv,
		input logic [YW-1:0] yv);
		cell_addr = AW'(AW'(yv) * AW'(MAX_WIDTH)) + AW'(xv);
	endfunction

	state_t      state_q, state_d;
	cell_step_t  step_q;
	logic [XW-1:0]     cx_q;
	logic [YW-1:0]     cy_q;
	logic [PASS_W-1:0] pass_q;
	logic              cp_vld_s1;
	logic [AW-1:0]     cp_addr_s1;
	res_flags_t        res_q;

	logic          accept, is_run, is_read, is_write, req_inside;
	logic [XW-1:0] req_x, xl, xr, cx_next;
	logic [YW-1:0] req_y, yu, yd, cy_next;
	logic [AW-1:0] req_addr, center_addr;
	logic          last_col, last_row, last_cell, last_pass;

	// request decode
	assign accept     = start && (state_q == ST_IDLE);
	assign is_run     = accept && (request.command == CMD_RUN);
	assign is_read    = accept && (request.command == CMD_READ);
	assign is_write   = accept && (request.command == CMD_WRITE);
	assign req_inside = (32'(request.cell_x) < MAX_WIDTH) && (32'(request.cell_y) < MAX_HEIGHT);
	assign req_x      = XW'(request.cell_x);
	assign req_y      = YW'(request.cell_y);
	assign req_addr   = cell_addr(req_x, req_y);

	// neighbours: x wraps, y clamps
	assign center_addr = cell_addr(cx_q, cy_q);
	assign last_col    = (XW1'(cx_q) + XW1'(1)) >= width_eff;
	assign last_row    = (YW1'(cy_q) + YW1'(1)) >= height_eff;
	assign last_cell   = last_col && last_row;
	assign last_pass   = (pass_q + PASS_W'(1)) == pass_count;
	assign xl = (cx_q == '0) ? XW'(width_eff - XW1'(1)) : cx_q - XW'(1);
	assign xr = last_col ? '0 : cx_q + XW'(1);
	assign yu = (cy_q == '0) ? '0 : cy_q - YW'(1);
	assign yd = last_row ? cy_q : cy_q + YW'(1);

	// raster walk over the region in use
	always_comb begin
		cx_next = last_col ? '0 : cx_q + XW'(1);
		cy_next = cy_q;
		if (last_col) begin
			cy_next = last_row ? '0 : cy_q + YW'(1);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (is_run) begin
					state_d = (pass_count == '0) ? ST_FINISH : ST_COPY;
				end
			end
			ST_COPY: begin
				if (last_cell) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_CELL;
			end
			ST_CELL: begin
				if (step_q == STEP_WB && last_cell) begin
					state_d = last_pass ? ST_FINISH : ST_COPY;
				end
			end
			ST_FINISH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		busy         = 1'b1;
		store_ctl    = '0;
		alu_ctl      = '0;
		grid_addr    = center_addr;
		snap_rd_addr = center_addr;
		store_ctl.snap_we = cp_vld_s1;
		case (state_q)
			ST_IDLE: begin
				busy               = 1'b0;
				grid_addr          = req_addr;
				store_ctl.grid_we  = is_write && req_inside;
				store_ctl.ocean_we = is_write && req_inside;
			end
			ST_CELL: begin
				case (step_q)
					STEP_L:  snap_rd_addr = cell_addr(xl, cy_q);
					STEP_R:  snap_rd_addr = cell_addr(xr, cy_q);
					STEP_U:  snap_rd_addr = cell_addr(cx_q, yu);
					STEP_D:  snap_rd_addr = cell_addr(cx_q, yd);
					default: snap_rd_addr = center_addr;
				endcase
				alu_ctl.load = (step_q == STEP_L);
				alu_ctl.add  = (step_q == STEP_R) || (step_q == STEP_U) ||
					(step_q == STEP_D) || (step_q == STEP_ACC);
				alu_ctl.mul  = (step_q == STEP_MUL);
				store_ctl.grid_we       = (step_q == STEP_WB);
				store_ctl.grid_from_alu = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	// state, counters and result flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			step_q    <= STEP_C;
			cx_q      <= '0;
			cy_q      <= '0;
			pass_q    <= '0;
			cp_vld_s1 <= 1'b0;
			res_q     <= '0;
		end else begin
			state_q   <= state_d;
			cp_vld_s1 <= (state_q == ST_COPY);
			case (state_q)
				ST_IDLE: begin
					step_q <= STEP_C;
					cx_q   <= '0;
					cy_q   <= '0;
					pass_q <= '0;
				end
				ST_COPY: begin
					cx_q <= cx_next;
					cy_q <= cy_next;
				end
				ST_CELL: begin
					step_q <= cell_step_t'(step_q + 3'd1);
					if (step_q == STEP_WB) begin
						cx_q <= cx_next;
						cy_q <= cy_next;
						if (last_cell) begin
							pass_q <= pass_q + PASS_W'(1);
						end
					end
				end
				default: begin
					step_q <= STEP_C;
				end
			endcase
			res_q.vld     <= is_read || (state_q == ST_FINISH);
			res_q.run     <= (state_q == ST_FINISH);
			res_q.in_grid <= is_read && req_inside;
		end
	end

	// snapshot write address is the centre address, registered alongside the temperature read
	always_ff @(posedge clk) begin
		cp_addr_s1 <= center_addr;
	end

	assign snap_wr_addr = cp_addr_s1;
	assign res_flags    = res_q;

endmodule

>>> hdl/grid_heat_diffusion.sv
// grid_heat_diffusion: top level, configuration registers, result ports
// depends on ghd_pkg, ghd_store, ghd_alu, ghd_ctrl
//
// channel   signals                              transfer when
// request   start, busy, request (request_t)     start && !busy
// result    done, result (result_t)              done (one cycle, no stall)
// config    cfg_valid, cfg_ready, cfg_index,     cfg_valid && cfg_ready
//           cfg_data
//
// write and read commands do not raise busy; a read result shows in the cycle
// after its transfer. a run of P passes over W x H cells keeps the block busy:
// per pass one copy sweep of the W x H cells through the snapshot memory
// port, a drain state, then eight steps of the shared update unit per cell.
// reset clears registers only; the memories hold nothing defined until
// written. the result side cannot stall.

module grid_heat_diffusion
	import ghd_pkg::*;
#(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  request_t              request,
	output logic                  done,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int XW1 = $clog2(MAX_WIDTH + 1);
	localparam int YW1 = $clog2(MAX_HEIGHT + 1);
	localparam int AW  = $clog2(MAX_WIDTH * MAX_HEIGHT);

	logic [COEF_W-1:0] coeff_ocean_q, coeff_land_q;
	logic [PASS_W-1:0] pass_count_q;
	logic [DIM_W-1:0]  width_q, height_q;

	logic [XW1-1:0]    width_eff;
	logic [YW1-1:0]    height_eff;
	store_ctl_t        store_ctl;
	alu_ctl_t          alu_ctl;
	res_flags_t        res_flags;
	logic [AW-1:0]     grid_addr, snap_rd_addr, snap_wr_addr;
	logic [TEMP_W-1:0] temp_rd, snap_rd, alu_temp;
	logic              ocean_rd;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_ocean_q <= COEFF_OCEAN_RST;
			coeff_land_q  <= COEFF_LAND_RST;
			pass_count_q  <= PASS_COUNT_RST;
			width_q       <= WIDTH_RST;
			height_q      <= HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_COEFF_OCEAN:   coeff_ocean_q <= cfg_data;
				REG_COEFF_LAND:    coeff_land_q  <= cfg_data;
				REG_PASS_COUNT:    pass_count_q  <= cfg_data[PASS_W-1:0];
				REG_WIDTH_IN_USE:  width_q       <= cfg_data[DIM_W-1:0];
				REG_HEIGHT_IN_USE: height_q      <= cfg_data[DIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// region in use, clamped to 1..max
	always_comb begin
		if (width_q == '0) begin
			width_eff = XW1'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			width_eff = XW1'(MAX_WIDTH);
		end else begin
			width_eff = XW1'(width_q);
		end
		if (height_q == '0) begin
			height_eff = YW1'(1);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			height_eff = YW1'(MAX_HEIGHT);
		end else begin
			height_eff = YW1'(height_q);
		end
	end

	ghd_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.request      (request),
		.width_eff    (width_eff),
		.height_eff   (height_eff),
		.pass_count   (pass_count_q),
		.busy         (busy),
		.store_ctl    (store_ctl),
		.grid_addr    (grid_addr),
		.snap_rd_addr (snap_rd_addr),
		.snap_wr_addr (snap_wr_addr),
		.alu_ctl      (alu_ctl),
		.res_flags    (res_flags)
	);

	ghd_store #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_store (
		.clk          (clk),
		.ctl          (store_ctl),
		.grid_addr    (grid_addr),
		.snap_rd_addr (snap_rd_addr),
		.snap_wr_addr (snap_wr_addr),
		.wr_temp      (request.temperature_in),
		.wr_ocean     (request.ocean_in),
		.alu_temp     (alu_temp),
		.temp_rd      (temp_rd),
		.ocean_rd     (ocean_rd),
		.snap_rd      (snap_rd)
	);

	ghd_alu u_alu (
		.clk         (clk),
		.ctl         (alu_ctl),
		.snap_rd     (snap_rd),
		.ocean       (ocean_rd),
		.coeff_ocean (coeff_ocean_q),
		.coeff_land  (coeff_land_q),
		.new_temp    (alu_temp)
	);

	// result: read data for reads inside the grid, zeros otherwise
	assign done                   = res_flags.vld;
	assign result.temperature_out = res_flags.in_grid ? temp_rd : '0;
	assign result.ocean_out       = res_flags.in_grid ? ocean_rd : 1'b0;
	assign result.run_done        = res_flags.run;

endmodule

>>> hdl/ghd_checker.sv
// ghd_port_checks: port level checks of command and result ordering
// depends on ghd_pkg; bound to grid_heat_diffusion at the end of this file

module ghd_port_checks
	import ghd_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input request_t request,
	input logic     done,
	input result_t  result
);

	// a read gives its result in the next cycle
	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && request.command == CMD_READ) |=> (done && !result.run_done))
		else $error("read transfer without result in next cycle");

	// a write gives no result
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && request.command == CMD_WRITE) |=> !done)
		else $error("write transfer produced a result");

	// a run keeps the block busy and does not finish at once
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && request.command == CMD_RUN) |=> (busy && !done))
		else $error("run transfer did not hold the block busy");

	// run completion carries zero cell fields
	a_run_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.run_done) |-> (result.temperature_out == '0 && !result.ocean_out))
		else $error("run completion with non-zero cell fields");

	// run completion only follows a busy period
	a_run_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.run_done) |-> $past(busy))
		else $error("run completion without preceding busy cycle");

endmodule

bind grid_heat_diffusion ghd_port_checks u_ghd_port_checks (.*);
